// ----- src/crsb_pkg.sv -----
// Package for the clipped run sprite blitter.
// Holds the register map, reset values and stream codes; no dependencies.
package crsb_pkg;

	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CLIP_ENABLE = 3'd0,
		REG_ORIGIN_X    = 3'd1,
		REG_ORIGIN_Y    = 3'd2,
		REG_CLIP_RIGHT  = 3'd3,
		REG_CLIP_BOTTOM = 3'd4,
		REG_ROW_STRIDE  = 3'd5
	} cfg_reg_t;

	localparam logic [7:0] END_OF_ROW = 8'hff;

	localparam int CLIP_RIGHT_RESET  = 638;
	localparam int CLIP_BOTTOM_RESET = 497;
	localparam int ROW_STRIDE_RESET  = 640;

endpackage

// ----- src/clipped_run_sprite_blitter.sv -----
// Top level of the clipped run sprite blitter: stream parser, clip test and
// address pipeline. Depends on crsb_pkg.
//
//  channel   signals                                           direction
//  -------   -----------------------------------------------   ---------
//  in        in_valid, in_stall, code_byte, start_of_sprite    to block
//  out       out_valid, out_stall, pixel_address, pixel_value,
//            screen_x, screen_y                                from block
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data          to block
//
// One byte is accepted every cycle unless in_stall is high. The parser state
// moves at the edge that accepts a byte; a kept pixel is registered in s1 and
// the row times stride multiply then fills the output register. The output
// register holds under out_stall and in_stall rises only when both s1 and the
// output register are full. Reset clears the parser, the valid flags and the
// configuration registers to their defaults.
module clipped_run_sprite_blitter
	import crsb_pkg::*;
#(
	parameter int ADDR_WIDTH  = 20,
	parameter int COORD_WIDTH = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    code_byte,
	input  logic                          start_of_sprite,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ADDR_WIDTH-1:0]         pixel_address,
	output logic [7:0]                    pixel_value,
	output logic signed [COORD_WIDTH+1:0] screen_x,
	output logic signed [COORD_WIDTH+1:0] screen_y,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [COORD_WIDTH:0]          cfg_data
);

	localparam int SW = COORD_WIDTH + 2;
	localparam int PW = 2 * COORD_WIDTH + 5;
	localparam int EW = (PW > ADDR_WIDTH) ? PW : ADDR_WIDTH;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_COUNT  = 2'd1,
		PH_PIXELS = 2'd2
	} phase_t;

	// Configuration registers.
	logic                          clip_enable_q;
	logic signed [COORD_WIDTH-1:0] origin_x_q;
	logic signed [COORD_WIDTH-1:0] origin_y_q;
	logic [COORD_WIDTH-1:0]        clip_right_q;
	logic [COORD_WIDTH-1:0]        clip_bottom_q;
	logic [COORD_WIDTH:0]          row_stride_q;

	// Parser state.
	phase_t                 phase_q;
	logic [7:0]             run_q;
	logic [COORD_WIDTH:0]   column_q;
	logic [COORD_WIDTH-1:0] row_q;

	phase_t                 phase_d;
	logic [7:0]             run_d;
	logic [COORD_WIDTH:0]   column_d;
	logic [COORD_WIDTH-1:0] row_d;
	phase_t                 phase_cur;
	logic [7:0]             run_cur;
	logic [COORD_WIDTH:0]   column_cur;
	logic [COORD_WIDTH-1:0] row_cur;
	logic [7:0]             run_dec;
	logic                   is_pixel;

	logic signed [SW:0]   sx;
	logic signed [SW-1:0] sy;
	logic                 in_window;
	logic                 keep;

	// Pipeline registers.
	logic                 valid_s1;
	logic signed [SW:0]   sx_s1;
	logic signed [SW-1:0] sy_s1;
	logic [7:0]           value_s1;
	logic signed [EW-1:0] addr_full;

	logic accept;
	logic out_load;

	assign cfg_ready = 1'b1;

	assign out_load = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !out_load;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_enable_q <= 1'b0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			clip_right_q  <= COORD_WIDTH'(CLIP_RIGHT_RESET);
			clip_bottom_q <= COORD_WIDTH'(CLIP_BOTTOM_RESET);
			row_stride_q  <= (COORD_WIDTH + 1)'(ROW_STRIDE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLIP_ENABLE: clip_enable_q <= cfg_data[0];
				REG_ORIGIN_X:    origin_x_q    <= cfg_data[COORD_WIDTH-1:0];
				REG_ORIGIN_Y:    origin_y_q    <= cfg_data[COORD_WIDTH-1:0];
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_data[COORD_WIDTH-1:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[COORD_WIDTH-1:0];
				REG_ROW_STRIDE:  row_stride_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A start flag restarts the parser before the byte of the same item is parsed.
	always_comb begin
		phase_cur  = start_of_sprite ? PH_SKIP : phase_q;
		run_cur    = start_of_sprite ? 8'd0 : run_q;
		column_cur = start_of_sprite ? '0 : column_q;
		row_cur    = start_of_sprite ? '0 : row_q;
		run_dec    = run_cur - 8'd1;
		phase_d    = phase_cur;
		run_d      = run_cur;
		column_d   = column_cur;
		row_d      = row_cur;
		is_pixel   = 1'b0;
		case (phase_cur)
			PH_COUNT: begin
				run_d   = code_byte;
				phase_d = (code_byte == 8'd0) ? PH_SKIP : PH_PIXELS;
			end
			PH_PIXELS: begin
				is_pixel = 1'b1;
				column_d = column_cur + 1'b1;
				run_d    = run_dec;
				phase_d  = (run_dec == 8'd0) ? PH_SKIP : PH_PIXELS;
			end
			default: begin
				if (code_byte == END_OF_ROW) begin
					row_d    = row_cur + 1'b1;
					column_d = '0;
					phase_d  = PH_SKIP;
				end else begin
					column_d = column_cur + (COORD_WIDTH + 1)'(code_byte);
					phase_d  = PH_COUNT;
				end
			end
		endcase
	end

	// The column sum can pass the output width, so it carries one extra bit; the
	// clip test and the address then see exact values.
	assign sx = (SW + 1)'(origin_x_q) + $signed({2'b00, column_cur});
	assign sy = SW'(origin_y_q) + $signed({2'b00, row_cur});

	assign in_window = !sx[SW] && (sx <= $signed({3'b000, clip_right_q}))
		&& !sy[SW-1] && (sy <= $signed({2'b00, clip_bottom_q}));
	assign keep = is_pixel && (!clip_enable_q || in_window);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			run_q   <= '0;
			column_q <= '0;
			row_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			column_q <= column_d;
			row_q   <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_s1    <= sx;
			sy_s1    <= sy;
			value_s1 <= code_byte;
		end
	end

	// Two's complement product taken modulo 2**EW, then cut to the address width.
	assign addr_full = EW'(sy_s1) * $signed(EW'(row_stride_q)) + EW'(sx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_address <= addr_full[ADDR_WIDTH-1:0];
			pixel_value   <= value_s1;
			screen_x      <= sx_s1[SW-1:0];
			screen_y      <= sy_s1;
		end
	end

endmodule

// ----- src/crsb_checker.sv -----
// Port-level checker for the clipped run sprite blitter and its bind.
// Depends on the top level clipped_run_sprite_blitter.
module crsb_checker #(
	parameter int ADDR_WIDTH  = 20,
	parameter int COORD_WIDTH = 12
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ADDR_WIDTH-1:0]         pixel_address,
	input logic [7:0]                    pixel_value,
	input logic signed [COORD_WIDTH+1:0] screen_x,
	input logic signed [COORD_WIDTH+1:0] screen_y
);

	// A held result keeps its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_address)
			&& $stable(pixel_value) && $stable(screen_x) && $stable(screen_y))
		else $error("held result changed");

	// Input backpressure only arises when the output side is full and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// With the output empty, a new result comes from an accepted byte via the s1 and output registers.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted item");

	// Taking the result frees the input side in the same cycle.
	a_no_stall_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while result was taken");

endmodule

bind clipped_run_sprite_blitter crsb_checker #(
	.ADDR_WIDTH(ADDR_WIDTH),
	.COORD_WIDTH(COORD_WIDTH)
) u_crsb_checker (.*);
